// ===== sv/b64d_pkg.sv =====
// Shared types, constants and the alphabet map for the Base64URL stream decoder.
// Used by b64d_step and base64url_stream_decoder; depends on nothing else.
`default_nettype none

package b64d_pkg;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;

   typedef enum logic [2:0] {
      STATUS_OK = 3'd0,
      STATUS_EMPTY = 3'd1,
      STATUS_PADDING = 3'd2,
      STATUS_LENGTH = 3'd3,
      STATUS_BAD_CHAR = 3'd4
   } status_type;

   typedef struct packed {
      logic [11:0] bit_buffer;
      logic [3:0] bit_count;
      logic [1:0] length_mod_four;
      logic seen_character;
      logic padding_seen;
      logic bad_char_seen;
   } state_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic has_char;
      logic end_of_text;
   } item_type;

   typedef struct packed {
      logic byte_valid;
      logic [7:0] out_byte;
      logic text_done;
      status_type status;
   } result_type;

   typedef struct packed {
      logic valid;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         s.value = 6'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         s.value = 6'(c - CHAR_LOWER_A) + 6'd26;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         s.value = 6'(c - CHAR_DIGIT_0) + 6'd52;
      end else if (c == CHAR_MINUS) begin
         s.value = 6'd62;
      end else if (c == CHAR_UNDERSCORE) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_step.sv =====
// Combinational decode of one character beat: next decoder state and the result.
// Depends on b64d_pkg.
`default_nettype none

module b64d_step (
   input  var b64d_pkg::state_type  state,
   input  var b64d_pkg::item_type   item,
   output b64d_pkg::state_type      state_next,
   output b64d_pkg::result_type     result
);

   b64d_pkg::sextet_type sextet;
   b64d_pkg::state_type  upd;
   logic [3:0]           count_sum;
   logic [11:0]          shifted;

   always_comb begin
      sextet = b64d_pkg::sextet_of(item.char_code);
      upd = state;
      shifted = '0;
      count_sum = state.bit_count + 4'd6;
      result = '{byte_valid: 1'b0, out_byte: 8'd0, text_done: 1'b0,
                 status: b64d_pkg::STATUS_OK};

      if (item.has_char) begin
         upd.seen_character = 1'b1;
         upd.length_mod_four = state.length_mod_four + 2'd1;
         if (item.char_code == b64d_pkg::CHAR_EQUALS) begin
            upd.padding_seen = 1'b1;
         end else if (!sextet.valid) begin
            upd.bad_char_seen = 1'b1;
         end
         if (sextet.valid) begin
            upd.bit_buffer = {state.bit_buffer[5:0], sextet.value};
            upd.bit_count = count_sum;
            if (count_sum >= 4'd8) begin
               upd.bit_count = count_sum - 4'd8;
               shifted = upd.bit_buffer >> upd.bit_count;
               result.out_byte = shifted[7:0];
               result.byte_valid = 1'b1;
            end
         end
      end

      state_next = upd;
      if (item.end_of_text) begin
         result.text_done = 1'b1;
         if (!upd.seen_character) begin
            result.status = b64d_pkg::STATUS_EMPTY;
         end else if (upd.padding_seen) begin
            result.status = b64d_pkg::STATUS_PADDING;
         end else if (upd.length_mod_four == 2'd1) begin
            result.status = b64d_pkg::STATUS_LENGTH;
         end else if (upd.bad_char_seen) begin
            result.status = b64d_pkg::STATUS_BAD_CHAR;
         end else begin
            result.status = b64d_pkg::STATUS_OK;
         end
         state_next = '0;
      end
   end

endmodule

`default_nettype wire

// ===== sv/base64url_stream_decoder.sv =====
// Top level of the unpadded Base64URL stream decoder: input register, decode
// step and result register. Depends on b64d_pkg and b64d_step.
//
// Usage: each req_ beat carries at most one text character (req_has_char) and
// may mark the end of the text (req_end_of_text). Every request beat gives
// exactly one rsp_ beat: rsp_byte_valid with rsp_out_byte when a byte is
// complete, and rsp_text_done with rsp_status on the closing beat. A nonzero
// status means the bytes already returned for that text are to be discarded.
// Requests wait in the input register, results in the response register; one
// beat is taken every cycle for as long as the receiver keeps rsp_ready high.
// When the receiver stalls, the response register holds its beat and the input
// register still takes one more beat before req_ready falls; both stages move
// again in the cycle rsp_ready returns. Synchronous reset empties both registers
// and clears the decoder state; every end of text clears the decoder state too.
`default_nettype none

module base64url_stream_decoder (
   input  var logic       clock,
   input  var logic       reset,
   input  var logic       req_valid,
   output logic           req_ready,
   input  var logic [7:0] req_char_code,
   input  var logic       req_has_char,
   input  var logic       req_end_of_text,
   output logic           rsp_valid,
   input  var logic       rsp_ready,
   output logic           rsp_byte_valid,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_text_done,
   output logic [2:0]     rsp_status
);

   logic                   item_valid_ff, item_valid_in;
   b64d_pkg::item_type     item_ff, item_in;
   logic                   result_valid_ff, result_valid_in;
   b64d_pkg::result_type   result_ff, result_in;
   b64d_pkg::state_type    state_ff, state_in;
   b64d_pkg::state_type    state_next;
   b64d_pkg::result_type   step_result;
   logic                   out_free;
   logic                   item_advance;

   b64d_step u_step (
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_next),
      .result     (step_result)
   );

   always_comb begin
      out_free = !result_valid_ff || rsp_ready;
      item_advance = item_valid_ff && out_free;
      req_ready = !item_valid_ff || item_advance;

      item_valid_in = item_valid_ff;
      item_in = item_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in = '{char_code: req_char_code, has_char: req_has_char,
                     end_of_text: req_end_of_text};
      end else if (item_advance) begin
         item_valid_in = 1'b0;
      end

      result_valid_in = result_valid_ff;
      result_in = result_ff;
      state_in = state_ff;
      if (item_advance) begin
         result_valid_in = 1'b1;
         result_in = step_result;
         state_in = state_next;
      end else if (rsp_ready) begin
         result_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      result_ff <= result_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         result_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         result_valid_ff <= result_valid_in;
         state_ff <= state_in;
      end
   end

   assign rsp_valid = result_valid_ff;
   assign rsp_byte_valid = result_ff.byte_valid;
   assign rsp_out_byte = result_ff.out_byte;
   assign rsp_text_done = result_ff.text_done;
   assign rsp_status = 3'(result_ff.status);

   ap_status_only_when_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_text_done) |-> (rsp_status == 3'(b64d_pkg::STATUS_OK)))
      else $error("status is nonzero on a beat that does not close a text");

   ap_byte_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_out_byte == 8'd0))
      else $error("out_byte is nonzero without byte_valid");

   ap_state_cleared_after_text: assert property (@(posedge clock) disable iff (reset)
      (item_advance && item_ff.end_of_text) |=> (state_ff == '0))
      else $error("decoder state not cleared after the end of a text");

   ap_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.bit_count <= 4'd6) && !state_ff.bit_count[0])
      else $error("bit count left its legal set of values");

   ap_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (item_valid_ff && result_valid_ff && !rsp_ready))
      else $error("request side stalled while a stage was free");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for base64url_stream_decoder: a short table of directed beats, then
// random texts under changing handshake gaps, all checked against a predictor or the table.
// Depends on b64d_pkg and the RTL of base64url_stream_decoder only.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS_PER_PHASE = 290;

   typedef struct {
      b64d_pkg::item_type   beat;
      logic                 fixed;
      b64d_pkg::result_type want;
   } stimulus_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_code = 8'd0;
   logic       req_has_char = 1'b0;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_byte_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_text_done;
   logic [2:0] rsp_status;

   logic                 row_fixed = 1'b0;
   b64d_pkg::result_type row_want = '0;

   int sender_gap_pct = 33;
   int receiver_gap_pct = 66;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   logic [11:0] pending_bits = '0;
   logic [3:0]  pending_count = '0;
   logic [1:0]  char_phase = '0;
   logic        got_char = 1'b0;
   logic        got_pad = 1'b0;
   logic        got_bad = 1'b0;

   b64d_pkg::result_type decoded_results[$];
   stimulus_row_type     directed_rows[$];

   base64url_stream_decoder uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_code(req_char_code),
      .req_has_char(req_has_char),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_out_byte(rsp_out_byte),
      .rsp_text_done(rsp_text_done),
      .rsp_status(rsp_status)
   );

   always begin
      #6;
      clock = 1'b1;
      #6;
      clock = 1'b0;
   end

   function automatic int alphabet_index(input logic [7:0] c);
      if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z)
         return int'(c - b64d_pkg::CHAR_UPPER_A);
      if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z)
         return int'(c - b64d_pkg::CHAR_LOWER_A) + 26;
      if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9)
         return int'(c - b64d_pkg::CHAR_DIGIT_0) + 52;
      if (c == b64d_pkg::CHAR_MINUS) return 62;
      if (c == b64d_pkg::CHAR_UNDERSCORE) return 63;
      return -1;
   endfunction

   function automatic logic [7:0] random_alphabet_char();
      int idx;
      idx = $urandom_range(63);
      if (idx < 26) return b64d_pkg::CHAR_UPPER_A + 8'(idx);
      if (idx < 52) return b64d_pkg::CHAR_LOWER_A + 8'(idx - 26);
      if (idx < 62) return b64d_pkg::CHAR_DIGIT_0 + 8'(idx - 52);
      if (idx == 62) return b64d_pkg::CHAR_MINUS;
      return b64d_pkg::CHAR_UNDERSCORE;
   endfunction

   function automatic b64d_pkg::result_type decode_beat(input b64d_pkg::item_type beat);
      b64d_pkg::result_type r;
      int sextet;
      r = '0;
      if (beat.has_char) begin
         sextet = alphabet_index(beat.char_code);
         got_char = 1'b1;
         char_phase = char_phase + 2'd1;
         if (beat.char_code == b64d_pkg::CHAR_EQUALS) begin
            got_pad = 1'b1;
         end else if (sextet < 0) begin
            got_bad = 1'b1;
         end
         if (sextet >= 0) begin
            pending_bits = {pending_bits[5:0], 6'(sextet)};
            pending_count = pending_count + 4'd6;
            if (pending_count >= 4'd8) begin
               pending_count = pending_count - 4'd8;
               r.out_byte = 8'(pending_bits >> pending_count);
               r.byte_valid = 1'b1;
            end
         end
      end
      if (beat.end_of_text) begin
         r.text_done = 1'b1;
         if (!got_char) begin
            r.status = b64d_pkg::STATUS_EMPTY;
         end else if (got_pad) begin
            r.status = b64d_pkg::STATUS_PADDING;
         end else if (char_phase == 2'd1) begin
            r.status = b64d_pkg::STATUS_LENGTH;
         end else if (got_bad) begin
            r.status = b64d_pkg::STATUS_BAD_CHAR;
         end else begin
            r.status = b64d_pkg::STATUS_OK;
         end
         pending_bits = '0;
         pending_count = '0;
         char_phase = '0;
         got_char = 1'b0;
         got_pad = 1'b0;
         got_bad = 1'b0;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int wanted);
      mismatch_count++;
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, wanted);
   endtask

   task automatic add_row(input logic [7:0] ch, input logic has, input logic eot,
                          input logic fixed, input logic bv, input logic [7:0] ob,
                          input logic td, input b64d_pkg::status_type st);
      stimulus_row_type row;
      row.beat.char_code = ch;
      row.beat.has_char = has;
      row.beat.end_of_text = eot;
      row.fixed = fixed;
      row.want.byte_valid = bv;
      row.want.out_byte = ob;
      row.want.text_done = td;
      row.want.status = st;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic send_beat(input b64d_pkg::item_type beat, input logic fixed,
                            input b64d_pkg::result_type want);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         req_char_code <= 8'($urandom_range(255));
         req_has_char <= 1'($urandom_range(1));
         req_end_of_text <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= beat.char_code;
      req_has_char <= beat.has_char;
      req_end_of_text <= beat.end_of_text;
      row_fixed <= fixed;
      row_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_texts(input int amount);
      int produced;
      int len;
      logic clean;
      logic close_on_char;
      b64d_pkg::item_type beat;
      produced = 0;
      while (produced < amount) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
         clean = ($urandom_range(99) < 80);
         close_on_char = 1'($urandom_range(1));
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) begin
               beat.char_code = 8'($urandom_range(255));
               beat.has_char = 1'b0;
               beat.end_of_text = 1'b0;
               send_beat(beat, 1'b0, '0);
            end
            beat.has_char = 1'b1;
            beat.end_of_text = close_on_char && (i == len - 1);
            if (clean || $urandom_range(7) != 0) begin
               beat.char_code = random_alphabet_char();
            end else if ($urandom_range(3) == 0) begin
               beat.char_code = b64d_pkg::CHAR_EQUALS;
            end else begin
               beat.char_code = 8'($urandom_range(255));
            end
            send_beat(beat, 1'b0, '0);
            produced++;
         end
         if (!close_on_char || len == 0) begin
            beat.char_code = 8'($urandom_range(255));
            beat.has_char = 1'b0;
            beat.end_of_text = 1'b1;
            send_beat(beat, 1'b0, '0);
            produced++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_gap_pct);
   end

   always @(posedge clock) begin : monitor
      b64d_pkg::item_type   taken;
      b64d_pkg::result_type want;
      logic                 moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            taken.char_code = req_char_code;
            taken.has_char = req_has_char;
            taken.end_of_text = req_end_of_text;
            want = decode_beat(taken);
            if (row_fixed) begin
               want = row_want;
            end
            decoded_results.insert(decoded_results.size(), want);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (decoded_results.size() == 0) begin
               flag_mismatch("result beat with nothing outstanding", rsp_out_byte, -1);
            end else begin
               want = decoded_results.pop_front();
               if (rsp_byte_valid !== want.byte_valid) begin
                  flag_mismatch("byte_valid", rsp_byte_valid, want.byte_valid);
               end
               if (rsp_out_byte !== want.out_byte) begin
                  flag_mismatch("out_byte", rsp_out_byte, want.out_byte);
               end
               if (rsp_text_done !== want.text_done) begin
                  flag_mismatch("text_done", rsp_text_done, want.text_done);
               end
               if (rsp_status !== want.status) begin
                  flag_mismatch("status", rsp_status, want.status);
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      // An empty text, then "TWFu" closing on its last character.
      add_row(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, b64d_pkg::STATUS_EMPTY);
      add_row("T", 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, b64d_pkg::STATUS_OK);
      add_row("W", 1'b1, 1'b0, 1'b1, 1'b1, 8'h4D, 1'b0, b64d_pkg::STATUS_OK);
      add_row("F", 1'b1, 1'b0, 1'b1, 1'b1, 8'h61, 1'b0, b64d_pkg::STATUS_OK);
      add_row("u", 1'b1, 1'b1, 1'b1, 1'b1, 8'h6E, 1'b1, b64d_pkg::STATUS_OK);
      // All-ones sextets, closed by a bare end marker.
      add_row(b64d_pkg::CHAR_UNDERSCORE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0,
              b64d_pkg::STATUS_OK);
      add_row(b64d_pkg::CHAR_UNDERSCORE, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0,
              b64d_pkg::STATUS_OK);
      add_row(b64d_pkg::CHAR_UNDERSCORE, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0,
              b64d_pkg::STATUS_OK);
      add_row(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, b64d_pkg::STATUS_OK);
      add_row(8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, b64d_pkg::STATUS_OK);
      add_row("0", 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, b64d_pkg::STATUS_OK);
      add_row("9", 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, b64d_pkg::STATUS_OK);
      add_row(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, b64d_pkg::STATUS_OK);
      add_row("z", 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, b64d_pkg::STATUS_OK);
      add_row(8'h41, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, b64d_pkg::STATUS_BAD_CHAR);
      add_row("Q", 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, b64d_pkg::STATUS_OK);
      add_row("Q", 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, b64d_pkg::STATUS_OK);
      add_row(b64d_pkg::CHAR_EQUALS, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0,
              b64d_pkg::STATUS_OK);
      add_row(b64d_pkg::CHAR_EQUALS, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1,
              b64d_pkg::STATUS_PADDING);
      // A lone '=' reports padding ahead of the length fault.
      add_row(b64d_pkg::CHAR_EQUALS, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1,
              b64d_pkg::STATUS_PADDING);
      add_row(b64d_pkg::CHAR_MINUS, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1,
              b64d_pkg::STATUS_LENGTH);
      add_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, b64d_pkg::STATUS_LENGTH);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].want);
      end
      send_random_texts(RANDOM_ITEMS_PER_PHASE);
      sender_gap_pct = 66;
      receiver_gap_pct = 33;
      send_random_texts(RANDOM_ITEMS_PER_PHASE);
      sender_gap_pct = 0;
      receiver_gap_pct = 0;
      send_random_texts(RANDOM_ITEMS_PER_PHASE);
      req_valid <= 1'b0;

      while (decoded_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (decoded_results.size() != 0) begin
         flag_mismatch("results never returned", 0, decoded_results.size());
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
